// ===== rtl/core/qsam_pkg.sv =====
// ----------------------------------------------------------------------------
// qsam_pkg
// Widths, constants and bundle types shared by the quaternion/scale to
// affine matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qsam_pkg;

  localparam int QUAT_W     = 16;
  localparam int SCL_W      = 16;
  localparam int TRANS_W    = 32;
  localparam int PROD_W     = 2 * QUAT_W;
  localparam int TERM_W     = PROD_W + 2;
  localparam int FULL_W     = TERM_W + SCL_W;
  localparam int OUT_W      = 32;
  localparam int ROT_FRAC   = 28;
  localparam int SCL_FRAC   = 8;
  localparam int OUT_FRAC   = 16;
  localparam int ROUND_SH   = ROT_FRAC + SCL_FRAC - OUT_FRAC;
  localparam int NUM_Q      = 4;
  localparam int NUM_AX     = 3;
  localparam int NUM_ENT    = 9;

  // quaternion component slots
  localparam int Q_X = 0;
  localparam int Q_Y = 1;
  localparam int Q_Z = 2;
  localparam int Q_W = 3;

  // product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;

  // func codes
  localparam logic FUNC_SCALED = 1'b0;
  localparam logic FUNC_ROT    = 1'b1;

  localparam logic signed [TERM_W-1:0] ROT_ONE = TERM_W'(1) << ROT_FRAC;

  // matrix row of each entry, selects the scale component
  localparam logic [1:0] ROW_OF [NUM_ENT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
                                              2'd1, 2'd2, 2'd2, 2'd2};

  typedef logic [QUAT_W-1:0]  quat_t;
  typedef logic [SCL_W-1:0]   scl_t;
  typedef logic [TRANS_W-1:0] trans_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [TERM_W-1:0]  term_t;
  typedef logic [FULL_W-1:0]  full_t;
  typedef logic [OUT_W-1:0]   ent_t;

  typedef quat_t  [NUM_Q-1:0]   quat_vec_t;
  typedef scl_t   [NUM_AX-1:0]  scl_vec_t;
  typedef trans_t [NUM_AX-1:0]  trans_vec_t;
  typedef prod_t  [NUM_ENT-1:0] prod_vec_t;
  typedef term_t  [NUM_ENT-1:0] term_vec_t;
  typedef full_t  [NUM_ENT-1:0] full_vec_t;
  typedef ent_t   [NUM_ENT-1:0] ent_vec_t;

  typedef struct packed {
    quat_vec_t  quat;
    scl_vec_t   scale;
    logic       func;
    trans_vec_t trans;
  } in_item_t;

  typedef struct packed {
    prod_vec_t  prod;
    scl_vec_t   scale;
    logic       func;
    trans_vec_t trans;
  } prod_item_t;

  typedef struct packed {
    term_vec_t  term;
    scl_vec_t   scale;
    logic       func;
    trans_vec_t trans;
  } term_item_t;

  typedef struct packed {
    full_vec_t  full;
    trans_vec_t trans;
  } full_item_t;

  typedef struct packed {
    ent_vec_t   ent;
    trans_vec_t origin;
  } out_item_t;

  // stage control: advance enable from downstream, valid from upstream
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/qsam_prod.sv =====
// ----------------------------------------------------------------------------
// qsam_prod
// Stage 1: the nine quaternion component products.
// ----------------------------------------------------------------------------
`default_nettype none

module qsam_prod (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire qsam_pkg::stage_ctl_t  ctl_i,
  input  wire qsam_pkg::in_item_t    item_i,
  output logic                       valid_o,
  output qsam_pkg::prod_item_t       item_o
);

  logic                  valid_q;
  qsam_pkg::prod_item_t  item_q;
  qsam_pkg::prod_item_t  item_d;

  function automatic qsam_pkg::prod_t mul(qsam_pkg::quat_t a, qsam_pkg::quat_t b);
    logic signed [qsam_pkg::PROD_W-1:0] p;
    p = $signed(a) * $signed(b);
    return p;
  endfunction

  always_comb begin
    item_d.prod[qsam_pkg::P_XX] = mul(item_i.quat[qsam_pkg::Q_X], item_i.quat[qsam_pkg::Q_X]);
    item_d.prod[qsam_pkg::P_YY] = mul(item_i.quat[qsam_pkg::Q_Y], item_i.quat[qsam_pkg::Q_Y]);
    item_d.prod[qsam_pkg::P_ZZ] = mul(item_i.quat[qsam_pkg::Q_Z], item_i.quat[qsam_pkg::Q_Z]);
    item_d.prod[qsam_pkg::P_XY] = mul(item_i.quat[qsam_pkg::Q_X], item_i.quat[qsam_pkg::Q_Y]);
    item_d.prod[qsam_pkg::P_XZ] = mul(item_i.quat[qsam_pkg::Q_X], item_i.quat[qsam_pkg::Q_Z]);
    item_d.prod[qsam_pkg::P_YZ] = mul(item_i.quat[qsam_pkg::Q_Y], item_i.quat[qsam_pkg::Q_Z]);
    item_d.prod[qsam_pkg::P_WX] = mul(item_i.quat[qsam_pkg::Q_W], item_i.quat[qsam_pkg::Q_X]);
    item_d.prod[qsam_pkg::P_WY] = mul(item_i.quat[qsam_pkg::Q_W], item_i.quat[qsam_pkg::Q_Y]);
    item_d.prod[qsam_pkg::P_WZ] = mul(item_i.quat[qsam_pkg::Q_W], item_i.quat[qsam_pkg::Q_Z]);
    item_d.scale = item_i.scale;
    item_d.func  = item_i.func;
    item_d.trans = item_i.trans;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.valid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/qsam_terms.sv =====
// ----------------------------------------------------------------------------
// qsam_terms
// Stage 2: doubled-product sums forming the nine rotation terms, Q6.28.
// ----------------------------------------------------------------------------
`default_nettype none

module qsam_terms (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire qsam_pkg::stage_ctl_t  ctl_i,
  input  wire qsam_pkg::prod_item_t  item_i,
  output logic                       valid_o,
  output qsam_pkg::term_item_t       item_o
);

  logic                  valid_q;
  qsam_pkg::term_item_t  item_q;
  qsam_pkg::term_item_t  item_d;
  logic signed [qsam_pkg::TERM_W-1:0] d [qsam_pkg::NUM_ENT];

  // 2 * product, sign extended to term width
  function automatic logic signed [qsam_pkg::TERM_W-1:0] dbl(qsam_pkg::prod_t p);
    return $signed({{(qsam_pkg::TERM_W-qsam_pkg::PROD_W-1){p[qsam_pkg::PROD_W-1]}},
                    p, 1'b0});
  endfunction

  always_comb begin
    for (int i = 0; i < qsam_pkg::NUM_ENT; i++) begin
      d[i] = dbl(item_i.prod[i]);
    end
    item_d.term[0] = qsam_pkg::ROT_ONE - (d[qsam_pkg::P_YY] + d[qsam_pkg::P_ZZ]);
    item_d.term[1] = d[qsam_pkg::P_XY] + d[qsam_pkg::P_WZ];
    item_d.term[2] = d[qsam_pkg::P_XZ] - d[qsam_pkg::P_WY];
    item_d.term[3] = d[qsam_pkg::P_XY] - d[qsam_pkg::P_WZ];
    item_d.term[4] = qsam_pkg::ROT_ONE - (d[qsam_pkg::P_XX] + d[qsam_pkg::P_ZZ]);
    item_d.term[5] = d[qsam_pkg::P_YZ] + d[qsam_pkg::P_WX];
    item_d.term[6] = d[qsam_pkg::P_XZ] + d[qsam_pkg::P_WY];
    item_d.term[7] = d[qsam_pkg::P_YZ] - d[qsam_pkg::P_WX];
    item_d.term[8] = qsam_pkg::ROT_ONE - (d[qsam_pkg::P_XX] + d[qsam_pkg::P_YY]);
    item_d.scale = item_i.scale;
    item_d.func  = item_i.func;
    item_d.trans = item_i.trans;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.valid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/qsam_scale.sv =====
// ----------------------------------------------------------------------------
// qsam_scale
// Stage 3: term times row scale (Q.36), or term aligned to Q.36 when the
// scale is bypassed.
// ----------------------------------------------------------------------------
`default_nettype none

module qsam_scale (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire qsam_pkg::stage_ctl_t  ctl_i,
  input  wire qsam_pkg::term_item_t  item_i,
  output logic                       valid_o,
  output qsam_pkg::full_item_t       item_o
);

  localparam int ExtW = qsam_pkg::FULL_W - qsam_pkg::TERM_W - qsam_pkg::SCL_FRAC;

  logic                  valid_q;
  qsam_pkg::full_item_t  item_q;
  qsam_pkg::full_item_t  item_d;
  logic signed [qsam_pkg::FULL_W-1:0] p;
  qsam_pkg::term_t       t;
  qsam_pkg::scl_t        s;

  always_comb begin
    p = '0;
    t = '0;
    s = '0;
    for (int i = 0; i < qsam_pkg::NUM_ENT; i++) begin
      t = item_i.term[i];
      s = item_i.scale[qsam_pkg::ROW_OF[i]];
      if (item_i.func == qsam_pkg::FUNC_ROT) begin
        p = $signed({{ExtW{t[qsam_pkg::TERM_W-1]}}, t, {qsam_pkg::SCL_FRAC{1'b0}}});
      end else begin
        p = $signed(t) * $signed(s);
      end
      item_d.full[i] = p;
    end
    item_d.trans = item_i.trans;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.valid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/qsam_round.sv =====
// ----------------------------------------------------------------------------
// qsam_round
// Stage 4: round to Q16.16 (nearest, ties up) and saturate; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsam_round (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire qsam_pkg::stage_ctl_t  ctl_i,
  input  wire qsam_pkg::full_item_t  item_i,
  output logic                       valid_o,
  output qsam_pkg::out_item_t        item_o
);

  localparam logic signed [qsam_pkg::FULL_W-1:0] Half =
    qsam_pkg::FULL_W'(1) << (qsam_pkg::ROUND_SH - 1);
  localparam int HiW = qsam_pkg::FULL_W - qsam_pkg::OUT_W + 1;

  logic                  valid_q;
  qsam_pkg::out_item_t   item_q;
  qsam_pkg::out_item_t   item_d;
  logic signed [qsam_pkg::FULL_W-1:0] sum;
  logic signed [qsam_pkg::FULL_W-1:0] r;
  logic [HiW-1:0]        hi;

  always_comb begin
    sum = '0;
    r   = '0;
    hi  = '0;
    for (int i = 0; i < qsam_pkg::NUM_ENT; i++) begin
      sum = $signed(item_i.full[i]) + Half;
      r   = sum >>> qsam_pkg::ROUND_SH;
      hi  = r[qsam_pkg::FULL_W-1:qsam_pkg::OUT_W-1];
      if (hi == '0 || hi == '1) begin
        item_d.ent[i] = r[qsam_pkg::OUT_W-1:0];
      end else if (r[qsam_pkg::FULL_W-1]) begin
        item_d.ent[i] = {1'b1, {(qsam_pkg::OUT_W-1){1'b0}}};
      end else begin
        item_d.ent[i] = {1'b0, {(qsam_pkg::OUT_W-1){1'b1}}};
      end
    end
    item_d.origin = item_i.trans;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.valid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/quat_scale_to_affine_matrix.sv =====
// ----------------------------------------------------------------------------
// quat_scale_to_affine_matrix
// Quaternion, per-row scale and translation to the rotation part and origin
// row of a 4x4 affine matrix, Q16.16 outputs.
//
// Input channel: in_valid_i / in_stall_o with quaternion (Q2.14), scale
// (Q8.8), translation (Q16.16) and func. Output channel: out_valid_o /
// out_stall_i with m00..m22 and origin_x..z. An item moves when valid is
// high and stall is low.
// Stages in order: products, term sums, scale multiply, round/saturate,
// each ending in a register. Throughput: one item per cycle while no stage
// holds; the nine 16x16 multipliers of stage 1 and the nine 34x16
// multipliers of stage 3 each take a new item every cycle unless stalled.
// When out_stall_i is high the last stage holds; bubbles in earlier stages
// still fill, and in_stall_o rises only once every stage holds an item.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quat_scale_to_affine_matrix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] quat_x_i,
  input  wire logic [15:0] quat_y_i,
  input  wire logic [15:0] quat_z_i,
  input  wire logic [15:0] quat_w_i,
  input  wire logic [31:0] trans_x_i,
  input  wire logic [31:0] trans_y_i,
  input  wire logic [31:0] trans_z_i,
  input  wire logic [15:0] scale_x_i,
  input  wire logic [15:0] scale_y_i,
  input  wire logic [15:0] scale_z_i,
  input  wire logic        func_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      m00_o,
  output logic [31:0]      m01_o,
  output logic [31:0]      m02_o,
  output logic [31:0]      m10_o,
  output logic [31:0]      m11_o,
  output logic [31:0]      m12_o,
  output logic [31:0]      m20_o,
  output logic [31:0]      m21_o,
  output logic [31:0]      m22_o,
  output logic [31:0]      origin_x_o,
  output logic [31:0]      origin_y_o,
  output logic [31:0]      origin_z_o
);

  qsam_pkg::in_item_t    in_item;
  qsam_pkg::prod_item_t  s1_item;
  qsam_pkg::term_item_t  s2_item;
  qsam_pkg::full_item_t  s3_item;
  qsam_pkg::out_item_t   s4_item;
  logic                  s1_valid, s2_valid, s3_valid, s4_valid;
  logic                  en1, en2, en3, en4;
  qsam_pkg::stage_ctl_t  ctl1, ctl2, ctl3, ctl4;

  assign en4 = !s4_valid || !out_stall_i;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  assign ctl1 = '{en: en1, valid: in_valid_i};
  assign ctl2 = '{en: en2, valid: s1_valid};
  assign ctl3 = '{en: en3, valid: s2_valid};
  assign ctl4 = '{en: en4, valid: s3_valid};

  assign in_stall_o = !en1;

  always_comb begin
    in_item.quat[qsam_pkg::Q_X] = quat_x_i;
    in_item.quat[qsam_pkg::Q_Y] = quat_y_i;
    in_item.quat[qsam_pkg::Q_Z] = quat_z_i;
    in_item.quat[qsam_pkg::Q_W] = quat_w_i;
    in_item.scale[0] = scale_x_i;
    in_item.scale[1] = scale_y_i;
    in_item.scale[2] = scale_z_i;
    in_item.func     = func_i;
    in_item.trans[0] = trans_x_i;
    in_item.trans[1] = trans_y_i;
    in_item.trans[2] = trans_z_i;
  end

  qsam_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl1),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  qsam_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl2),
    .item_i  (s1_item),
    .valid_o (s2_valid),
    .item_o  (s2_item)
  );

  qsam_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl3),
    .item_i  (s2_item),
    .valid_o (s3_valid),
    .item_o  (s3_item)
  );

  qsam_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl4),
    .item_i  (s3_item),
    .valid_o (s4_valid),
    .item_o  (s4_item)
  );

  assign out_valid_o = s4_valid;
  assign m00_o       = s4_item.ent[0];
  assign m01_o       = s4_item.ent[1];
  assign m02_o       = s4_item.ent[2];
  assign m10_o       = s4_item.ent[3];
  assign m11_o       = s4_item.ent[4];
  assign m12_o       = s4_item.ent[5];
  assign m20_o       = s4_item.ent[6];
  assign m21_o       = s4_item.ent[7];
  assign m22_o       = s4_item.ent[8];
  assign origin_x_o  = s4_item.origin[0];
  assign origin_y_o  = s4_item.origin[1];
  assign origin_z_o  = s4_item.origin[2];

endmodule

`default_nettype wire
